@@ design/cku_pkg.sv @@
// Shared constants and helpers for the clamped 5x5 kernel upsampler.
// Holds the opcodes and the mirror-symmetric tap index function.
// No dependencies.
package cku_pkg;

	localparam int TAPS = 25;
	localparam int TAP_IDX_BITS = 8;

	typedef enum logic {
		OP_WEIGHT = 1'b0,
		OP_COLUMN = 1'b1
	} opcode_t;

	// last output coordinate of a block, N-1, for shift 1..3
	function automatic logic [2:0] last_coord(input logic [1:0] sh);
		logic [2:0] r;
		begin
			case (sh)
				2'd2: r = 3'd3;
				2'd3: r = 3'd7;
				default: r = 3'd1;
			endcase
			return r;
		end
	endfunction

	// triangular index of the weight for output (oy,ox) and window tap (py,px)
	function automatic logic [TAP_IDX_BITS-1:0] tap_index(input logic [1:0] sh,
			input logic [2:0] oy_in, input logic [2:0] ox_in,
			input logic [2:0] py_in, input logic [2:0] px_in);
		int h, oy, ox, py, px, j, i, lo, hi, t;
		begin
			h = (sh == 2'd3) ? 4 : (sh == 2'd2) ? 2 : 1;
			oy = int'(oy_in);
			ox = int'(ox_in);
			py = int'(py_in);
			px = int'(px_in);
			if (oy >= h) begin
				oy = 2 * h - 1 - oy;
				py = 4 - py;
			end
			if (ox >= h) begin
				ox = 2 * h - 1 - ox;
				px = 4 - px;
			end
			j = 5 * oy + py;
			i = 5 * ox + px;
			lo = (i < j) ? i : j;
			hi = (i < j) ? j : i;
			t = 5 * h * lo - ((lo * (lo - 1)) >>> 1) + hi - lo;
			return t[TAP_IDX_BITS-1:0];
		end
	endfunction

endpackage

@@ design/cku_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data updates only on a read enable. No dependencies.
module cku_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 210
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

@@ design/clamped_5x5_kernel_upsampler_top.sv @@
// Top level of the clamped 5x5 kernel upsampler: window, job sequencer,
// 25-tap MAC pipeline and output register. Uses cku_pkg and cku_ram.
//
// channel   dir  handshake                    contents
// s_axis    in   s_axis_tvalid/s_axis_tready   weight load or pixel column
// m_axis    out  m_axis_tvalid/m_axis_tready   one upsampled sample, tlast ends block
// cfg       in   cfg_we                        upsample_shift
//
// A weight load or a column that leaves the window unfilled issues no samples.
// A column that fills the window issues N*N samples (4, 16 or 64), one per
// cycle unless m_axis stalls; the next word is taken on the cycle of the last
// issue. The rate is set by the 25 weight-table copies, each read once per
// unstalled cycle. Issues pass s1 to s4 and the output register. Reset clears
// window, fill and pipeline valids; the weight table needs loading before use.
// An output stall freezes the whole pipeline, RAM read registers included.
module clamped_5x5_kernel_upsampler_top
	import cku_pkg::*;
#(
	parameter int PIXEL_BITS = 16,
	parameter int WEIGHT_BITS = 16,
	parameter int WEIGHT_TABLE_DEPTH = 210
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// weight_index, weight_value, pixel_row_m2, pixel_row_m1, pixel_center_row,
	// pixel_row_p1, pixel_row_p2, first_of_row, zero pad
	input  logic [((8 + WEIGHT_BITS + 5 * PIXEL_BITS + 1 + 7) / 8) * 8 - 1:0] s_axis_tdata,
	input  logic [0:0] s_axis_tuser, // opcode
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// sample_value, sub_row, sub_col, zero pad
	output logic [((PIXEL_BITS + 6 + 7) / 8) * 8 - 1:0] m_axis_tdata,
	output logic m_axis_tlast,
	input  logic cfg_we,
	input  logic [1:0] cfg_wdata
);

	localparam int P = PIXEL_BITS;
	localparam int W = WEIGHT_BITS;
	localparam int AW = $clog2(WEIGHT_TABLE_DEPTH);
	localparam int OUT_W = ((P + 6 + 7) / 8) * 8;
	localparam int PW = P + W;
	localparam int RW = PW + 3;
	localparam int ACC_W = PW + 5;
	localparam int PIX0 = 8 + W;
	localparam int FOR_BIT = 8 + W + 5 * P;

	// config
	logic [1:0] shift_q;
	logic [1:0] shift_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			shift_q <= 2'd1;
		else if (cfg_we)
			shift_q <= cfg_wdata;
	end

	assign shift_eff = (shift_q == 2'd0) ? 2'd1 : shift_q;

	// input decode
	logic [7:0]          in_idx;
	logic signed [W-1:0] in_wval;
	logic                in_first;
	logic                in_acc, load_acc, col_acc;

	assign in_idx = s_axis_tdata[7:0];
	assign in_wval = s_axis_tdata[8 +: W];
	assign in_first = s_axis_tdata[FOR_BIT];
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign load_acc = in_acc && (s_axis_tuser[0] == OP_WEIGHT);
	assign col_acc = in_acc && (s_axis_tuser[0] == OP_COLUMN);

	// window and fill
	logic signed [P-1:0] win_q [TAPS];
	logic signed [P-1:0] win_next [TAPS];
	logic [2:0]          fill_q;
	logic [2:0]          fill_base;
	logic                launch;

	always_comb begin
		for (int r = 0; r < 5; r++) begin
			for (int c = 0; c < 4; c++)
				win_next[r * 5 + c] = win_q[r * 5 + c + 1];
			win_next[r * 5 + 4] = s_axis_tdata[PIX0 + r * P +: P];
		end
	end

	assign fill_base = in_first ? 3'd0 : fill_q;
	assign launch = (fill_base >= 3'd4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 3'd0;
			for (int k = 0; k < TAPS; k++)
				win_q[k] <= '0;
		end else if (col_acc) begin
			fill_q <= launch ? 3'd5 : fill_base + 3'd1;
			win_q <= win_next;
		end
	end

	// job sequencer
	logic signed [P-1:0] job_win_q [TAPS];
	logic                busy_q;
	logic [2:0]          oy_q, ox_q;
	logic [2:0]          nm1;
	logic                advance;
	logic                last_issue;

	assign nm1 = last_coord(shift_eff);
	assign advance = !m_axis_tvalid || m_axis_tready;
	assign last_issue = busy_q && (oy_q == nm1) && (ox_q == nm1);
	assign s_axis_tready = !busy_q || (advance && last_issue);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			oy_q <= 3'd0;
			ox_q <= 3'd0;
		end else if (col_acc && launch) begin
			busy_q <= 1'b1;
			oy_q <= 3'd0;
			ox_q <= 3'd0;
		end else if (busy_q && advance) begin
			if (last_issue) begin
				busy_q <= 1'b0;
			end else if (ox_q == nm1) begin
				ox_q <= 3'd0;
				oy_q <= oy_q + 3'd1;
			end else begin
				ox_q <= ox_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (col_acc && launch)
			job_win_q <= win_next;
	end

	// weight table copies, one per tap
	logic [AW-1:0]       raddr [TAPS];
	logic [TAPS-1:0]     tap_ok;
	logic [W-1:0]        rdata [TAPS];
	logic                wr_en;

	assign wr_en = load_acc && (32'(in_idx) < WEIGHT_TABLE_DEPTH);

	always_comb begin
		logic [TAP_IDX_BITS-1:0] t;
		for (int k = 0; k < TAPS; k++) begin
			t = tap_index(shift_eff, oy_q, ox_q, 3'(k / 5), 3'(k % 5));
			raddr[k] = t[AW-1:0];
			tap_ok[k] = (32'(t) < WEIGHT_TABLE_DEPTH);
		end
	end

	for (genvar g = 0; g < TAPS; g++) begin : g_wt
		cku_ram #(
			.WIDTH(W),
			.DEPTH(WEIGHT_TABLE_DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (wr_en),
			.waddr (in_idx[AW-1:0]),
			.wdata (in_wval),
			.re    (advance),
			.raddr (raddr[g]),
			.rdata (rdata[g])
		);
	end

	// MAC pipeline
	logic                v_s1, v_s2, v_s3, v_s4;
	logic [2:0]          oy_s1, oy_s2, oy_s3, oy_s4;
	logic [2:0]          ox_s1, ox_s2, ox_s3, ox_s4;
	logic                last_s1, last_s2, last_s3, last_s4;
	logic [TAPS-1:0]     tap_ok_s1;
	logic signed [P-1:0] win_s1 [TAPS];
	logic signed [P-1:0] rlo_s1 [5];
	logic signed [P-1:0] rhi_s1 [5];
	logic signed [P-1:0] rlo_c [5];
	logic signed [P-1:0] rhi_c [5];
	logic signed [PW-1:0] prod_s2 [TAPS];
	logic signed [P-1:0] lo_s2, hi_s2, lo_s3, hi_s3, lo_s4, hi_s4;
	logic signed [P-1:0] lo_c, hi_c;
	logic signed [RW-1:0] row_s3 [5];
	logic signed [ACC_W-1:0] acc_s4;
	logic signed [ACC_W-1:0] acc_c;
	logic signed [RW-1:0] row_c [5];
	logic signed [PW-1:0] prod_c [TAPS];

	always_comb begin
		for (int r = 0; r < 5; r++) begin
			rlo_c[r] = job_win_q[r * 5];
			rhi_c[r] = job_win_q[r * 5];
			for (int c = 1; c < 5; c++) begin
				if (job_win_q[r * 5 + c] < rlo_c[r])
					rlo_c[r] = job_win_q[r * 5 + c];
				if (job_win_q[r * 5 + c] > rhi_c[r])
					rhi_c[r] = job_win_q[r * 5 + c];
			end
		end
		lo_c = rlo_s1[0];
		hi_c = rhi_s1[0];
		for (int r = 1; r < 5; r++) begin
			if (rlo_s1[r] < lo_c)
				lo_c = rlo_s1[r];
			if (rhi_s1[r] > hi_c)
				hi_c = rhi_s1[r];
		end
		for (int k = 0; k < TAPS; k++)
			prod_c[k] = PW'(win_s1[k]) * (tap_ok_s1[k] ? PW'($signed(rdata[k])) : PW'(0));
		for (int r = 0; r < 5; r++) begin
			row_c[r] = '0;
			for (int c = 0; c < 5; c++)
				row_c[r] = row_c[r] + RW'(prod_s2[r * 5 + c]);
		end
		// round half up before the floor shift
		acc_c = ACC_W'(1) <<< (W - 3);
		for (int r = 0; r < 5; r++)
			acc_c = acc_c + ACC_W'(row_s3[r]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (advance) begin
			v_s1 <= busy_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			oy_s1 <= oy_q;
			ox_s1 <= ox_q;
			last_s1 <= last_issue;
			tap_ok_s1 <= tap_ok;
			win_s1 <= job_win_q;
			rlo_s1 <= rlo_c;
			rhi_s1 <= rhi_c;

			oy_s2 <= oy_s1;
			ox_s2 <= ox_s1;
			last_s2 <= last_s1;
			prod_s2 <= prod_c;
			lo_s2 <= lo_c;
			hi_s2 <= hi_c;

			oy_s3 <= oy_s2;
			ox_s3 <= ox_s2;
			last_s3 <= last_s2;
			row_s3 <= row_c;
			lo_s3 <= lo_s2;
			hi_s3 <= hi_s2;

			oy_s4 <= oy_s3;
			ox_s4 <= ox_s3;
			last_s4 <= last_s3;
			acc_s4 <= acc_c;
			lo_s4 <= lo_s3;
			hi_s4 <= hi_s3;
		end
	end

	// round, clamp, output register
	logic signed [ACC_W-1:0] shifted;
	logic signed [P-1:0]     sample_c;
	logic signed [P-1:0]     sample_q;
	logic [2:0]              out_oy_q, out_ox_q;
	logic                    out_last_q;
	logic                    out_valid_q;

	always_comb begin
		shifted = acc_s4 >>> (W - 2);
		if (shifted < ACC_W'(lo_s4))
			sample_c = lo_s4;
		else if (shifted > ACC_W'(hi_s4))
			sample_c = hi_s4;
		else
			sample_c = shifted[P-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sample_q <= sample_c;
			out_oy_q <= oy_s4;
			out_ox_q <= ox_s4;
			out_last_q <= last_s4;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast = out_last_q;
	assign m_axis_tdata = OUT_W'({out_ox_q, out_oy_q, sample_q});

	// checks
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !advance) |=> ($stable(oy_q) && $stable(ox_q)))
		else $error("issue counters moved during stall");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 3'd5)
		else $error("window fill out of range");

	a_launch: assert property (@(posedge clk) disable iff (!arst_n)
		(col_acc && launch) |=> (busy_q && oy_q == 3'd0 && ox_q == 3'd0))
		else $error("full window did not start a block");

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !last_issue) |-> !s_axis_tready)
		else $error("word taken mid block");

	a_last_diag: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (out_oy_q == out_ox_q))
		else $error("tlast off the block corner");

endmodule

@@ tb/tb_clamped_5x5_kernel_upsampler_top.sv @@
// Self-checking testbench for clamped_5x5_kernel_upsampler_top.
// Loads the weight table, pushes pixel columns under each upsampling shift and
// checks every sample against an in-bench predictor. Depends on cku_pkg.
module tb_clamped_5x5_kernel_upsampler_top;
	timeunit 1ns;
	timeprecision 1ps;
	import cku_pkg::*;

	localparam int TABLE_DEPTH = 210;
	localparam int IN_W = 112;
	localparam int OUT_W = 24;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct {
		opcode_t op;
		logic [7:0] idx;
		logic signed [15:0] wval;
		logic signed [15:0] px [5];
		logic first;
	} in_word_t;

	typedef struct packed {
		logic [15:0] sample;
		logic [2:0] row;
		logic [2:0] col;
		logic last;
	} sample_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic [0:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;
	logic m_axis_tlast;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_wdata = 2'd0;

	clamped_5x5_kernel_upsampler_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	in_word_t pending_words [$];
	in_word_t held_word;
	sample_t expected_samples [$];
	logic signed [15:0] pix_window [5][5];
	logic signed [15:0] weight_mem [TABLE_DEPTH];
	int window_fill = 0;
	logic [1:0] cur_shift = 2'd1;
	int errors = 0;
	int cycles = 0;
	bit quiet = 0;
	int src_gap = 0;
	int sink_stall = 0;

	function automatic int weight_slot(int n, int oy, int ox, int py, int px);
		int h, j, i, lo, hi;
		h = n / 2;
		if (oy >= h) begin
			oy = n - 1 - oy;
			py = 4 - py;
		end
		if (ox >= h) begin
			ox = n - 1 - ox;
			px = 4 - px;
		end
		j = 5 * oy + py;
		i = 5 * ox + px;
		lo = (i < j) ? i : j;
		hi = (i < j) ? j : i;
		return 5 * h * lo - lo * (lo - 1) / 2 + hi - lo;
	endfunction

	// advance the window model by one word and queue the samples it yields
	task automatic predict_samples(input in_word_t w);
		longint acc, v, lo, hi;
		int n, t;
		sample_t s;
		if (w.op == OP_WEIGHT) begin
			if (w.idx < TABLE_DEPTH) weight_mem[w.idx] = w.wval;
			return;
		end
		if (w.first) window_fill = 0;
		for (int r = 0; r < 5; r++) begin
			for (int c = 0; c < 4; c++) pix_window[r][c] = pix_window[r][c+1];
			pix_window[r][4] = w.px[r];
		end
		if (window_fill < 5) window_fill++;
		if (window_fill < 5) return;
		lo = pix_window[0][0];
		hi = lo;
		for (int r = 0; r < 5; r++)
			for (int c = 0; c < 5; c++) begin
				if (pix_window[r][c] < lo) lo = pix_window[r][c];
				if (pix_window[r][c] > hi) hi = pix_window[r][c];
			end
		n = 1 << ((cur_shift == 2'd0) ? 1 : cur_shift);
		for (int oy = 0; oy < n; oy++)
			for (int ox = 0; ox < n; ox++) begin
				acc = 0;
				for (int r = 0; r < 5; r++)
					for (int c = 0; c < 5; c++) begin
						t = weight_slot(n, oy, ox, r, c);
						if (t < TABLE_DEPTH)
							acc += longint'(pix_window[r][c]) * longint'(weight_mem[t]);
					end
				v = (acc + 64'sd8192) >>> 14;
				if (v < lo) v = lo;
				if (v > hi) v = hi;
				s.sample = v[15:0];
				s.row = oy[2:0];
				s.col = ox[2:0];
				s.last = (oy == n - 1) && (ox == n - 1);
				expected_samples.push_back(s);
			end
	endtask

	function automatic logic [IN_W-1:0] pack_word(input in_word_t w);
		logic [IN_W-1:0] d;
		d = '0;
		d[7:0] = w.idx;
		d[23:8] = w.wval;
		for (int r = 0; r < 5; r++) d[24 + 16*r +: 16] = w.px[r];
		d[104] = w.first;
		return d;
	endfunction

	// source side
	always @(posedge clk or negedge arst_n) begin
		logic nv;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) predict_samples(held_word);
			if (!s_axis_tvalid || s_axis_tready) begin
				nv = 1'b0;
				if (src_gap > 0) begin
					src_gap--;
				end else if (!quiet && $urandom_range(0, 9) == 0) begin
					src_gap = $urandom_range(1, 17) - 1;
				end else if (pending_words.size() > 0) begin
					held_word = pending_words.pop_front();
					nv = 1'b1;
					s_axis_tdata <= pack_word(held_word);
					s_axis_tuser <= held_word.op;
				end
				s_axis_tvalid <= nv;
			end
		end
	end

	// sink side: stall bursts and checking
	always @(posedge clk or negedge arst_n) begin
		sample_t got, want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tdata[15:0], m_axis_tdata[18:16], m_axis_tdata[21:19],
					m_axis_tlast};
				if (expected_samples.size() == 0) begin
					errors++;
					$display("%0t: unexpected sample: actual val=%h row=%0d col=%0d last=%0d",
						$time, got.sample, got.row, got.col, got.last);
				end else begin
					want = expected_samples.pop_front();
					if (got !== want) begin
						errors++;
						$display("%0t: mismatch expected val=%h row=%0d col=%0d last=%0d",
							$time, want.sample, want.row, want.col, want.last);
						$display("%0t:          actual   val=%h row=%0d col=%0d last=%0d",
							$time, got.sample, got.row, got.col, got.last);
					end
				end
			end
			if (sink_stall > 0) begin
				sink_stall--;
				m_axis_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				sink_stall = $urandom_range(1, 17) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic push_weight(input int idx, input int val);
		in_word_t w;
		w.op = OP_WEIGHT;
		w.idx = idx[7:0];
		w.wval = val[15:0];
		foreach (w.px[r]) w.px[r] = 16'($urandom());
		w.first = 1'($urandom_range(0, 1));
		pending_words.push_back(w);
	endtask

	task automatic push_column(input bit first, input int a, input int b, input int c,
			input int d, input int e);
		in_word_t w;
		w.op = OP_COLUMN;
		w.idx = 8'($urandom());
		w.wval = 16'($urandom());
		w.px[0] = a[15:0];
		w.px[1] = b[15:0];
		w.px[2] = c[15:0];
		w.px[3] = d[15:0];
		w.px[4] = e[15:0];
		w.first = first;
		pending_words.push_back(w);
	endtask

	function automatic int rand_pixel();
		case ($urandom_range(0, 9))
			0: return 32767;
			1: return -32768;
			2: return $urandom_range(0, 255) - 128;
			default: return $urandom();
		endcase
	endfunction

	task automatic wait_idle();
		wait (pending_words.size() == 0 && !s_axis_tvalid && expected_samples.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_shift(input logic [1:0] sh);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= sh;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_shift = sh;
	endtask

	task automatic random_phase(input int count);
		int k;
		for (k = 0; k < count; k++) begin
			if ($urandom_range(0, 9) == 0)
				push_weight($urandom_range(0, 255), $urandom());
			else
				push_column($urandom_range(0, 11) == 0, rand_pixel(), rand_pixel(),
					rand_pixel(), rand_pixel(), rand_pixel());
		end
	endtask

	logic [1:0] shift_plan [7] = '{2'd1, 2'd2, 2'd3, 2'd0, 2'd3, 2'd1, 2'd2};

	initial begin
		foreach (pix_window[r, c]) pix_window[r][c] = '0;
		foreach (weight_mem[i]) weight_mem[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		write_shift(2'd1);

		// every table entry gets written before any sample can read it
		for (int i = 0; i < TABLE_DEPTH; i++)
			push_weight(i, (i == 0) ? 32767 : (i == 1) ? -32768 : $urandom());
		push_weight(210, 12345);
		push_weight(255, -1);

		push_column(1, 32767, 32767, 32767, 32767, 32767);
		repeat (4) push_column(0, 32767, 32767, 32767, 32767, 32767);
		repeat (5) push_column(0, -32768, -32768, -32768, -32768, -32768);
		push_column(0, 32767, -32768, 0, 32767, -32768);
		push_weight(3, -32768);
		push_column(0, -32768, 32767, 1, -1, 0);
		// row restart in the middle of a fill
		push_column(1, 100, 200, 300, 400, 500);
		push_column(0, 1, 2, 3, 4, 5);
		push_column(1, -5, -4, -3, -2, -1);
		repeat (4) push_column(0, rand_pixel(), rand_pixel(), rand_pixel(),
			rand_pixel(), rand_pixel());
		wait_idle();

		for (int p = 0; p < 7; p++) begin
			write_shift(shift_plan[p]);
			if (p == 6) quiet = 1;
			push_column(1, rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel(),
				rand_pixel());
			random_phase(25);
			wait_idle();
		end

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ files.f @@
design/cku_pkg.sv
design/cku_ram.sv
design/clamped_5x5_kernel_upsampler_top.sv
tb/tb_clamped_5x5_kernel_upsampler_top.sv
